// ===== rtl/cmg_pkg.sv =====
// Package for the cylinder mesh generator: widths, register indexes, phase codes,
// sine table constants and the structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none
package cmg_pkg;

    localparam int CNT_W   = 10;
    localparam int IDX_W   = 17;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 25;
    localparam int NUM_W   = 24;
    localparam int DEN_W   = 10;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    localparam logic [CFG_A_W-1:0] REG_TOP_RADIUS    = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_BOTTOM_RADIUS = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_HEIGHT        = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_AXIAL_COUNT   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_HEIGHT_COUNT  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_ANGLE_STEP    = 3'd5;

    localparam logic [3:0] PH_SIDE_V = 4'd0;
    localparam logic [3:0] PH_SIDE_T = 4'd1;
    localparam logic [3:0] PH_TOP_V  = 4'd2;
    localparam logic [3:0] PH_TOP_T  = 4'd3;
    localparam logic [3:0] PH_BOT_V  = 4'd4;
    localparam logic [3:0] PH_BOT_T  = 4'd5;
    localparam logic [3:0] PH_DONE   = 4'd6;

    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;

    localparam logic [1:0] PART_SIDE   = 2'd0;
    localparam logic [1:0] PART_TOP    = 2'd1;
    localparam logic [1:0] PART_BOTTOM = 2'd2;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

    typedef struct packed {
        logic clear;
        logic div_start;
        logic div_height;
        logic ang_load;
        logic rom_cos;
        logic mul_z;
        logic mul_x;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_load;
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              part;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic                    last;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/cmg_req_if.sv =====
// Request channel of the cylinder mesh generator: valid, ready and the restart flag.
// No dependencies.
`default_nettype none
interface cmg_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmg_elem_if.sv =====
// Element channel of the cylinder mesh generator: valid, ready and one mesh element.
// Depends on cmg_pkg.
`default_nettype none
interface cmg_elem_if
    import cmg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [1:0]              part;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic                    last;
    modport source (output valid, output kind, output part, output pos_x, output pos_y,
                    output pos_z, output index_a, output index_b, output index_c,
                    output last, input ready);
    modport sink (input valid, input kind, input part, input pos_x, input pos_y,
                  input pos_z, input index_a, input index_b, input index_c,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmg_cfg_if.sv =====
// Configuration write channel of the cylinder mesh generator: valid, ready, index, data.
// Depends on cmg_pkg.
`default_nettype none
interface cmg_cfg_if
    import cmg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] index;
    logic [CFG_D_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmg_div.sv =====
// Restoring divider for the ring radius and ring height, one quotient bit per cycle.
// Depends on cmg_pkg.
`default_nettype none
module cmg_div
    import cmg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    neg,
    input  wire logic [NUM_W-1:0]        mag,
    input  wire logic [DEN_W-1:0]        den,
    output logic                         done,
    output logic signed [RAD_W-1:0]      quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            den_next  = den;
            neg_next  = neg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
endmodule
`default_nettype wire

// ===== rtl/cmg_sine_rom.sv =====
// Sine table in signed Q1.14, built at elaboration, with a registered read port.
// Depends on cmg_pkg.
`default_nettype none
module cmg_sine_rom
    import cmg_pkg::*;
#(
    parameter int SINE_DEPTH = 1024
) (
    input  wire logic                    clk,
    input  wire logic [15:0]             angle,
    output logic signed [15:0]           q
);
    localparam int AW = $clog2(SINE_DEPTH);

    typedef logic signed [15:0] rom_t [SINE_DEPTH];

    function automatic rom_t build_sine();
        rom_t              tab;
        longint unsigned   a;
        longint unsigned   x2;
        longint unsigned   t;
        longint            s;
        longint unsigned   v;
        logic              neg;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            a   = (TWO_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
            neg = 1'b0;
            if (a >= PI_Q30)
            begin
                a   = a - PI_Q30;
                neg = 1'b1;
            end
            if (a > HALF_PI_Q30)
                a = PI_Q30 - a;
            x2 = (a * a) >> 30;
            t  = a;
            s  = longint'(a);
            for (int n = 1; n <= 7; n++)
            begin
                t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - longint'(t);
                else
                    s = s + longint'(t);
            end
            if (s < 0)
                s = 0;
            v = (64'(s) + 64'd32768) >> 16;
            tab[k] = neg ? -$signed(16'(v)) : $signed(16'(v));
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_sine();

    logic [29:0]             scaled;
    logic [AW-1:0]           addr;
    logic signed [15:0]      q_reg;

    assign scaled = 30'(angle) * 30'(SINE_DEPTH);
    assign addr   = scaled[16 +: AW];

    always_ff @(posedge clk)
    begin
        q_reg <= SINE_ROM[addr];
    end

    assign q = q_reg;
endmodule
`default_nettype wire

// ===== rtl/cmg_dp.sv =====
// Datapath of the cylinder mesh generator: configuration registers, sequence counters,
// ring divider, sine lookup, position multipliers and the result register.
// Depends on cmg_pkg, cmg_div and cmg_sine_rom.
`default_nettype none
module cmg_dp
    import cmg_pkg::*;
#(
    parameter int MAX_AXIAL  = 256,
    parameter int MAX_RINGS  = 256,
    parameter int SINE_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_index,
    input  wire logic [CFG_D_W-1:0] cfg_data,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    output res_t                    res
);
    logic [14:0] top_r_reg, bot_r_reg, height_reg;
    logic [8:0]  axial_reg, hcount_reg;
    logic [15:0] step_reg;

    logic [3:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] ring_reg, ring_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             second_reg, second_next;
    logic [IDX_W-1:0] cb_reg, cb_next;
    logic signed [RAD_W-1:0] radius_reg, radius_next;
    logic signed [POS_W-1:0] hgt_reg, hgt_next;

    logic [15:0]             ang_reg;
    logic signed [40:0]      prod_x_reg, prod_z_reg;
    logic signed [15:0]      rom_q;
    logic [15:0]             rom_angle;
    logic                    div_h_reg;
    res_t                    res_reg, res_next;

    logic [CNT_W-1:0]        a_eff, h_eff, r_cnt;
    logic signed [16:0]      d_rad;
    logic signed [41:0]      num_rad, num_hgt;
    logic signed [CNT_W+1:0] h_minus;
    logic                    div_neg;
    logic [NUM_W-1:0]        div_mag;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic signed [RAD_W-1:0] div_q;
    logic signed [40:0]      sum_x, sum_z;
    logic [IDX_W-1:0]        irr, i1r, jj;
    logic [CNT_W:0]          col_inc, ring_inc;

    always_comb
    begin
        if (axial_reg < 9'd3)
            a_eff = CNT_W'(3);
        else if (32'(axial_reg) > MAX_AXIAL)
            a_eff = CNT_W'(MAX_AXIAL);
        else
            a_eff = CNT_W'(axial_reg);
        if (hcount_reg < 9'd1)
            h_eff = CNT_W'(1);
        else if (32'(hcount_reg) > MAX_RINGS)
            h_eff = CNT_W'(MAX_RINGS);
        else
            h_eff = CNT_W'(hcount_reg);
    end
    assign r_cnt = a_eff + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_r_reg  <= 15'd256;
            bot_r_reg  <= 15'd256;
            height_reg <= 15'd512;
            axial_reg  <= 9'd16;
            hcount_reg <= 9'd4;
            step_reg   <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP_RADIUS:    top_r_reg  <= cfg_data[14:0];
                REG_BOTTOM_RADIUS: bot_r_reg  <= cfg_data[14:0];
                REG_HEIGHT:        height_reg <= cfg_data[14:0];
                REG_AXIAL_COUNT:   axial_reg  <= cfg_data[8:0];
                REG_HEIGHT_COUNT:  hcount_reg <= cfg_data[8:0];
                REG_ANGLE_STEP:    step_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign d_rad   = $signed({2'b00, bot_r_reg}) - $signed({2'b00, top_r_reg});
    assign num_rad = 42'(d_rad) * $signed({2'b00, ring_reg});
    assign h_minus = $signed({2'b00, h_eff}) - $signed({1'b0, ring_reg, 1'b0});
    assign num_hgt = $signed({27'd0, height_reg}) * 42'(h_minus);

    always_comb
    begin
        if (cmd.div_height)
        begin
            div_neg = num_hgt[41];
            div_mag = num_hgt[41] ? NUM_W'(-num_hgt) : NUM_W'(num_hgt);
            div_den = {h_eff[DEN_W-2:0], 1'b0};
        end
        else
        begin
            div_neg = num_rad[41];
            div_mag = num_rad[41] ? NUM_W'(-num_rad) : NUM_W'(num_rad);
            div_den = DEN_W'(h_eff);
        end
    end

    cmg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .neg   (div_neg),
        .mag   (div_mag),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign rom_angle = cmd.rom_cos ? ang_reg + 16'd16384 : ang_reg;

    cmg_sine_rom #(
        .SINE_DEPTH (SINE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .angle (rom_angle),
        .q     (rom_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            div_h_reg <= cmd.div_height;
        if (cmd.ang_load)
            ang_reg <= 16'(col_reg * step_reg);
        if (cmd.mul_z)
            prod_z_reg <= radius_reg * 41'(rom_q);
        if (cmd.mul_x)
            prod_x_reg <= radius_reg * 41'(rom_q);
        if (cmd.finish)
            res_reg <= res_next;
    end

    assign sum_x   = prod_x_reg + 41'sd8192;
    assign sum_z   = prod_z_reg + 41'sd8192;
    assign irr     = IDX_W'(ring_reg) * IDX_W'(r_cnt);
    assign i1r     = irr + IDX_W'(r_cnt);
    assign jj      = IDX_W'(col_reg);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign ring_inc = {1'b0, ring_reg} + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        ring_next   = ring_reg;
        col_next    = col_reg;
        second_next = second_reg;
        cb_next     = cb_reg;
        radius_next = radius_reg;
        hgt_next    = hgt_reg;
        res_next    = '0;
        if (cmd.clear)
        begin
            phase_next  = PH_SIDE_V;
            ring_next   = '0;
            col_next    = '0;
            second_next = 1'b0;
            cb_next     = '0;
            radius_next = '0;
            hgt_next    = '0;
        end
        else if (div_done)
        begin
            if (div_h_reg)
                hgt_next = POS_W'(div_q);
            else
                radius_next = $signed({10'd0, top_r_reg}) + div_q;
        end
        else if (cmd.finish)
        begin
            case (phase_reg)
                PH_SIDE_V:
                begin
                    res_next.kind  = KIND_VERTEX;
                    res_next.part  = PART_SIDE;
                    res_next.pos_x = sum_x[29:14];
                    res_next.pos_y = hgt_reg;
                    res_next.pos_z = sum_z[29:14];
                    col_next = col_inc[CNT_W-1:0];
                    if (col_inc > {1'b0, a_eff})
                    begin
                        col_next = '0;
                        ring_next = ring_inc[CNT_W-1:0];
                        if (ring_inc > {1'b0, h_eff})
                        begin
                            phase_next = PH_SIDE_T;
                            ring_next  = '0;
                        end
                    end
                end
                PH_SIDE_T:
                begin
                    res_next.kind = KIND_TRIANGLE;
                    res_next.part = PART_SIDE;
                    if (!second_reg)
                    begin
                        res_next.index_a = i1r + jj + 1'b1;
                        res_next.index_b = i1r + jj;
                        res_next.index_c = irr + jj;
                    end
                    else
                    begin
                        res_next.index_a = irr + jj + 1'b1;
                        res_next.index_b = i1r + jj + 1'b1;
                        res_next.index_c = irr + jj;
                    end
                    second_next = !second_reg;
                    if (second_reg)
                    begin
                        col_next = col_inc[CNT_W-1:0];
                        if (col_inc >= {1'b0, a_eff})
                        begin
                            col_next  = '0;
                            ring_next = ring_inc[CNT_W-1:0];
                            if (ring_inc >= {1'b0, h_eff})
                            begin
                                phase_next  = PH_TOP_V;
                                ring_next   = '0;
                                cb_next     = IDX_W'(h_eff + 1'b1) * IDX_W'(r_cnt);
                                radius_next = $signed({10'd0, top_r_reg});
                                hgt_next    = $signed({2'b00, height_reg[14:1]});
                            end
                        end
                    end
                end
                PH_TOP_V, PH_BOT_V:
                begin
                    res_next.kind = KIND_VERTEX;
                    res_next.part = (phase_reg == PH_TOP_V) ? PART_TOP : PART_BOTTOM;
                    res_next.pos_y = hgt_reg;
                    if (col_reg <= a_eff)
                    begin
                        res_next.pos_x = sum_x[29:14];
                        res_next.pos_z = sum_z[29:14];
                    end
                    col_next = col_inc[CNT_W-1:0];
                    if (col_inc > {1'b0, r_cnt})
                    begin
                        col_next   = '0;
                        phase_next = phase_reg + 1'b1;
                    end
                end
                PH_TOP_T:
                begin
                    res_next.kind    = KIND_TRIANGLE;
                    res_next.part    = PART_TOP;
                    res_next.index_a = cb_reg + IDX_W'(r_cnt);
                    res_next.index_b = cb_reg + jj + 1'b1;
                    res_next.index_c = cb_reg + jj;
                    col_next = col_inc[CNT_W-1:0];
                    if (col_inc >= {1'b0, a_eff})
                    begin
                        col_next    = '0;
                        phase_next  = PH_BOT_V;
                        cb_next     = cb_reg + IDX_W'(a_eff) + 2'd2;
                        radius_next = $signed({10'd0, bot_r_reg});
                        hgt_next    = -$signed({2'b00, height_reg[14:1]});
                    end
                end
                PH_BOT_T:
                begin
                    res_next.kind    = KIND_TRIANGLE;
                    res_next.part    = PART_BOTTOM;
                    res_next.index_a = cb_reg + IDX_W'(r_cnt);
                    res_next.index_b = cb_reg + jj;
                    res_next.index_c = cb_reg + jj + 1'b1;
                    res_next.last    = (col_inc >= {1'b0, a_eff});
                    col_next = col_inc[CNT_W-1:0];
                    if (col_inc >= {1'b0, a_eff})
                    begin
                        col_next   = '0;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    res_next.kind = KIND_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIDE_V;
            ring_reg   <= '0;
            col_reg    <= '0;
            second_reg <= 1'b0;
            cb_reg     <= '0;
            radius_reg <= '0;
            hgt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ring_reg   <= ring_next;
            col_reg    <= col_next;
            second_reg <= second_next;
            cb_reg     <= cb_next;
            radius_reg <= radius_next;
            hgt_reg    <= hgt_next;
        end
    end

    assign stat.need_load = (phase_reg == PH_SIDE_V) && (col_reg == '0);
    assign stat.div_done  = div_done;
    assign res            = res_reg;
endmodule
`default_nettype wire

// ===== rtl/cmg_ctrl.sv =====
// Controller of the cylinder mesh generator: sequences one request through ring
// division, sine lookup and multiplication, and owns the request and element handshakes.
// Depends on cmg_pkg.
`default_nettype none
module cmg_ctrl
    import cmg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    input  wire logic  req_restart,
    output logic       req_ready,
    output logic       elem_valid,
    input  wire logic  elem_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_DIV_R  = 4'd2;
    localparam logic [3:0] S_DIV_H  = 4'd3;
    localparam logic [3:0] S_ANG    = 4'd4;
    localparam logic [3:0] S_SIN    = 4'd5;
    localparam logic [3:0] S_COS    = 4'd6;
    localparam logic [3:0] S_MULX   = 4'd7;
    localparam logic [3:0] S_FORM   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || elem_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.clear  = req_restart;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.need_load)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_R;
                end
                else
                    state_next = S_ANG;
            end
            S_DIV_R:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start  = 1'b1;
                    cmd.div_height = 1'b1;
                    state_next     = S_DIV_H;
                end
            end
            S_DIV_H:
            begin
                if (stat.div_done)
                    state_next = S_ANG;
            end
            S_ANG:
            begin
                cmd.ang_load = 1'b1;
                state_next   = S_SIN;
            end
            S_SIN:
            begin
                state_next = S_COS;
            end
            S_COS:
            begin
                cmd.rom_cos = 1'b1;
                cmd.mul_z   = 1'b1;
                state_next  = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (elem_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign elem_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/cylinder_mesh_generator_unit.sv =====
// Top level of the cylinder mesh generator: joins the controller and the datapath.
// Depends on cmg_pkg, the three channel interfaces, cmg_ctrl and cmg_dp.
//
//   channel | direction | payload                                   | handshake
//   req     | in        | restart                                   | valid / ready
//   elem    | out       | kind part pos_x pos_y pos_z index_a..c last | valid / ready
//   cfg     | in        | index data                                | valid / ready
//
// A request runs through the decide, angle, sine, cosine, multiply and form states into
// the output register, and each side ring's first vertex first waits on the serial divider.
// A new request is accepted while the previous result waits in the output register.
// Reset puts the sequence at its first element and the registers at their default values.
// A stalled element channel holds the controller in its form state until the register frees.
`default_nettype none
module cylinder_mesh_generator_unit
    import cmg_pkg::*;
#(
    parameter int MAX_AXIAL  = 256,
    parameter int MAX_RINGS  = 256,
    parameter int SINE_DEPTH = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cmg_req_if.sink   req,
    cmg_elem_if.source elem,
    cmg_cfg_if.sink   cfg
);
    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    assign cfg.ready = 1'b1;

    cmg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_restart (req.restart),
        .req_ready   (req.ready),
        .elem_valid  (elem.valid),
        .elem_ready  (elem.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    cmg_dp #(
        .MAX_AXIAL  (MAX_AXIAL),
        .MAX_RINGS  (MAX_RINGS),
        .SINE_DEPTH (SINE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    assign elem.kind    = res.kind;
    assign elem.part    = res.part;
    assign elem.pos_x   = res.pos_x;
    assign elem.pos_y   = res.pos_y;
    assign elem.pos_z   = res.pos_z;
    assign elem.index_a = res.index_a;
    assign elem.index_b = res.index_b;
    assign elem.index_c = res.index_c;
    assign elem.last    = res.last;
endmodule
`default_nettype wire

// ===== rtl/cmg_checker.sv =====
// Port checker for the cylinder mesh generator and the bind that attaches it.
// Depends on cmg_pkg and cylinder_mesh_generator_unit.
`default_nettype none
module cmg_checker
    import cmg_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    req_valid,
    input wire logic                    req_ready,
    input wire logic                    elem_valid,
    input wire logic                    elem_ready,
    input wire logic [1:0]              kind,
    input wire logic [1:0]              part,
    input wire logic signed [POS_W-1:0] pos_x,
    input wire logic [IDX_W-1:0]        index_a,
    input wire logic                    last
);
    a_elem_hold: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && !elem_ready |=> elem_valid && $stable(kind) && $stable(index_a))
        else $error("Element changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Second request accepted before the transaction completed.");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && kind == KIND_DONE |-> pos_x == '0 && index_a == '0 && !last)
        else $error("Done element carries data.");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && last |-> kind == KIND_TRIANGLE && part == PART_BOTTOM)
        else $error("Last flag on an element other than a bottom triangle.");
endmodule

bind cylinder_mesh_generator_unit cmg_checker u_cmg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .elem_valid (elem.valid),
    .elem_ready (elem.ready),
    .kind       (elem.kind),
    .part       (elem.part),
    .pos_x      (elem.pos_x),
    .index_a    (elem.index_a),
    .last       (elem.last)
);
`default_nettype wire
